### design/xsr_pkg.sv
// ---------------------------------------------------------------------------
// xsr_pkg
// Shared constants, types and step functions for the xoshiro256++ generator.
// ---------------------------------------------------------------------------
package xsr_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_RESEED = 2'd1;
    localparam logic [1:0] OP_JUMP   = 2'd2;

    // SplitMix64 increment and mixing multipliers
    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MIX2   = 64'h94d049bb133111eb;

    // jump polynomial, word 0 in the lowest bits; bit k is jump step k
    localparam logic [255:0] JUMP_POLY = {
        64'h39abdc4529b1661c,
        64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c,
        64'h180ec6d33cfd0aba
    };

    // four 64-bit generator words
    typedef logic [3:0][63:0] gen_state_t;

    // request into the SplitMix64 unit
    typedef struct packed {
        logic        start;
        logic [63:0] acc;
    } sm_req_t;

    // status and result from the SplitMix64 unit
    typedef struct packed {
        logic        done;
        logic [63:0] value;
        logic [63:0] acc;
    } sm_rsp_t;

    // rotate left by 23
    function automatic logic [63:0] xsr_rotl23(input logic [63:0] x);
        return {x[40:0], x[63:41]};
    endfunction

    // one xoshiro256 state transition (xor, shift and rotate only)
    function automatic gen_state_t xsr_advance(input gen_state_t s);
        gen_state_t  n;
        logic [63:0] t;
        t    = s[1] << 17;
        n    = s;
        n[2] = s[2] ^ s[0];
        n[3] = s[3] ^ s[1];
        n[1] = s[1] ^ n[2];
        n[0] = s[0] ^ n[3];
        n[2] = n[2] ^ t;
        n[3] = {n[3][18:0], n[3][63:19]};
        return n;
    endfunction

endpackage

### design/xsr_splitmix.sv
// ---------------------------------------------------------------------------
// xsr_splitmix
// One SplitMix64 step on a single shared 32x32 multiplier. Each 64-bit
// modular product is built from three partial products.
// ---------------------------------------------------------------------------
module xsr_splitmix
    import xsr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  sm_req_t req,
    output sm_rsp_t rsp
);

    localparam logic [1:0] SM_IDLE = 2'd0;
    localparam logic [1:0] SM_MUL  = 2'd1;
    localparam logic [1:0] SM_MIX  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        round_reg, round_next;
    logic        done_reg, done_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] part_reg, part_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] res_reg, res_next;

    logic [63:0] sum;
    logic [63:0] mconst;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // operand select for the shared multiplier
    always_comb begin
        mconst = round_reg ? SM_MIX2 : SM_MIX1;
        case (phase_reg)
            2'd0: begin
                mul_a = z_reg[31:0];
                mul_b = mconst[31:0];
            end
            2'd1: begin
                mul_a = z_reg[31:0];
                mul_b = mconst[63:32];
            end
            2'd2: begin
                mul_a = z_reg[63:32];
                mul_b = mconst[31:0];
            end
            default: begin
                mul_a = z_reg[31:0];
                mul_b = mconst[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sum   = req.acc + SM_GOLDEN;

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        z_next     = z_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        case (state_reg)
            SM_IDLE: begin
                if (req.start) begin
                    acc_next   = sum;
                    z_next     = sum ^ (sum >> 30);
                    round_next = 1'b0;
                    phase_next = 2'd0;
                    state_next = SM_MUL;
                end
            end
            SM_MUL: begin
                // register each partial product, then fold it in
                part_next  = mul_p;
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0: ;
                    2'd1: prod_next = part_reg;
                    2'd2: prod_next = prod_reg + {part_reg[31:0], 32'd0};
                    default: begin
                        prod_next  = prod_reg + {part_reg[31:0], 32'd0};
                        state_next = SM_MIX;
                    end
                endcase
            end
            SM_MIX: begin
                if (!round_reg) begin
                    z_next     = prod_reg ^ (prod_reg >> 27);
                    round_next = 1'b1;
                    phase_next = 2'd0;
                    state_next = SM_MUL;
                end else begin
                    res_next   = prod_reg ^ (prod_reg >> 31);
                    done_next  = 1'b1;
                    state_next = SM_IDLE;
                end
            end
            default: state_next = SM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SM_IDLE;
            phase_reg <= 2'd0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        part_reg <= part_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
    assign rsp.acc   = acc_reg;

endmodule

### design/xoshiro256pp_generator_top.sv
// ---------------------------------------------------------------------------
// xoshiro256pp_generator_top
// xoshiro256++ generator with draw, reseed and jump-ahead operations.
// ---------------------------------------------------------------------------
// The operation code arrives on s_tuser and the seed on s_tdata. A draw
// computes its result in the draw output state and loads it into the output
// register once that register is free; the next item is taken while that
// result waits. A reseed runs four SplitMix64 steps on one shared 32x32
// multiplier. A jump walks the 256 polynomial bits one per cycle. After
// reset the block seeds itself with zero before s_tready first rises.
// Operation code 3 is consumed and ignored.
module xoshiro256pp_generator_top
    import xsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed_value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] random_value
);

    localparam logic [2:0] ST_INIT     = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DRAW_OUT = 3'd2;
    localparam logic [2:0] ST_SEED     = 3'd3;
    localparam logic [2:0] ST_JUMP     = 3'd4;

    logic [2:0]  state_reg, state_next;
    gen_state_t  words_reg, words_next;
    gen_state_t  jacc_reg, jacc_next;
    gen_state_t  words_adv;
    gen_state_t  jacc_mix;
    logic [7:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] base_reg, base_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    sm_req_t sm_req;
    sm_rsp_t sm_rsp;

    xsr_splitmix u_splitmix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sm_req),
        .rsp     (sm_rsp)
    );

    assign words_adv = xsr_advance(words_reg);
    assign jacc_mix  = JUMP_POLY[cnt_reg] ? (jacc_reg ^ words_reg) : jacc_reg;

    // operation sequencer
    always_comb begin
        state_next   = state_reg;
        words_next   = words_reg;
        jacc_next    = jacc_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        sm_req.start = 1'b0;
        sm_req.acc   = sm_rsp.acc;
        case (state_reg)
            ST_INIT: begin
                // seed with zero after reset
                sm_req.start = 1'b1;
                sm_req.acc   = '0;
                idx_next     = 2'd0;
                state_next   = ST_SEED;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        OP_DRAW: begin
                            sum_next   = words_reg[0] + words_reg[3];
                            base_next  = words_reg[0];
                            words_next = words_adv;
                            state_next = ST_DRAW_OUT;
                        end
                        OP_RESEED: begin
                            sm_req.start = 1'b1;
                            sm_req.acc   = s_tdata;
                            idx_next     = 2'd0;
                            state_next   = ST_SEED;
                        end
                        OP_JUMP: begin
                            jacc_next  = '0;
                            cnt_next   = 8'd0;
                            state_next = ST_JUMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRAW_OUT: begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = xsr_rotl23(sum_reg) + base_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SEED: begin
                if (sm_rsp.done) begin
                    words_next[idx_reg] = sm_rsp.value;
                    if (idx_reg == 2'd3) begin
                        // never leave the all-zero state in place
                        if ((words_reg[0] | words_reg[1] | words_reg[2] |
                             sm_rsp.value) == 64'd0) begin
                            words_next[0] = 64'd1;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        idx_next     = idx_reg + 2'd1;
                        sm_req.start = 1'b1;
                    end
                end
            end
            ST_JUMP: begin
                // accumulate on polynomial bits, advance every cycle
                jacc_next  = jacc_mix;
                words_next = words_adv;
                cnt_next   = cnt_reg + 8'd1;
                if (cnt_reg == 8'd255) begin
                    words_next = jacc_mix;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= 8'd0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        words_reg  <= words_next;
        jacc_reg   <= jacc_next;
        sum_reg    <= sum_next;
        base_reg   <= base_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // the generator never rests in the all-zero state
    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (words_reg != '0))
        else $error("generator words all zero while idle");

    // seeding results arrive only while seeding
    a_done_in_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        sm_rsp.done |-> (state_reg == ST_SEED))
        else $error("splitmix result outside seeding");

    // a new result is loaded only by the draw output step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DRAW_OUT))
        else $error("result raised outside draw");

    // reseed and jump hold off further items
    a_busy_after_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_RESEED || s_tuser == OP_JUMP))
        |=> !s_tready)
        else $error("item taken during long operation");
`endif

endmodule

### verif/tb_xoshiro256pp_generator_top.sv
// ---------------------------------------------------------------------------
// tb_xoshiro256pp_generator_top
// Self-checking bench for the xoshiro256++ generator: draw, reseed, jump.
// ---------------------------------------------------------------------------
// A directed table covers the seed extremes, every operation, the unused
// operation code and back-to-back draws. A long random run follows: mostly
// draws, with reseeds and jumps mixed in. Both stream sides idle in random
// bursts, except near the end. Every item taken on the input side goes
// through a local generator model, and each draw queues the value the block
// must return.
module tb_xoshiro256pp_generator_top;
    import xsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operation code that carries no meaning and must be dropped
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int CALM_ITEMS    = 200;
    localparam int DRAIN_CYCLES  = 300;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] seed;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    logic [63:0] gen_words [4];
    logic [63:0] draw_values [$];
    logic [63:0] want;
    stim_row_t   directed_rows [DIRECTED_ROWS];
    int          errors;
    bit          calm;

    xoshiro256pp_generator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------------
    // generator model
    // ---------------------------------------------------------------------

    // SplitMix64 output function on an already incremented accumulator
    function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
        z = (z ^ (z >> 30)) * SM_MIX1;
        z = (z ^ (z >> 27)) * SM_MIX2;
        return z ^ (z >> 31);
    endfunction

    // expand a seed into the four words; never leave the all-zero state
    function automatic void seed_words(input logic [63:0] seed);
        logic [63:0] acc;
        acc = seed;
        for (int w = 0; w < 4; w++) begin
            acc          = acc + SM_GOLDEN;
            gen_words[w] = splitmix_mix(acc);
        end
        if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 64'd0)
            gen_words[0] = 64'd1;
    endfunction

    // produce the ++ output and advance the words by one step
    function automatic logic [63:0] step_words();
        logic [63:0] sum;
        logic [63:0] out;
        logic [63:0] shifted;
        sum          = gen_words[0] + gen_words[3];
        out          = ((sum << 23) | (sum >> 41)) + gen_words[0];
        shifted      = gen_words[1] << 17;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ shifted;
        gen_words[3] = (gen_words[3] << 45) | (gen_words[3] >> 19);
        return out;
    endfunction

    // advance by 2^128: fold the words selected by the polynomial bits
    function automatic void jump_words();
        logic [63:0] fold [4];
        logic [63:0] discard;
        for (int w = 0; w < 4; w++)
            fold[w] = 64'd0;
        for (int k = 0; k < 256; k++) begin
            if (JUMP_POLY[k]) begin
                for (int w = 0; w < 4; w++)
                    fold[w] = fold[w] ^ gen_words[w];
            end
            discard = step_words();
        end
        for (int w = 0; w < 4; w++)
            gen_words[w] = fold[w];
    endfunction

    // update the model for one accepted item; queue a value for a draw
    function automatic void apply_item(input logic [1:0] op, input logic [63:0] seed);
        case (op)
            OP_DRAW: begin
                draw_values.push_back(step_words());
            end
            OP_RESEED: begin
                seed_words(seed);
            end
            OP_JUMP: begin
                jump_words();
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // monitor: check results first, then fold in the item taken this edge
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (draw_values.size() == 0) begin
                    $error("random_value with no draw pending: actual %h", m_tdata);
                    errors++;
                end else begin
                    want = draw_values.pop_front();
                    if (m_tdata !== want) begin
                        $error("random_value mismatch: expected %h, actual %h", want, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata);
        end
    end

    // ---------------------------------------------------------------------
    // result side: stall in random bursts until the calm tail
    // ---------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge aclk);
            end
        end
    end

    // present one item and hold it until it is taken
    task automatic send_item(input logic [1:0] op, input logic [63:0] seed);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid for a random burst now and then
    task automatic source_pause();
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        int          taken;
        int          pick;
        logic [1:0]  op;
        logic [63:0] seed;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 64'd0;
        s_tuser  = OP_DRAW;
        errors   = 0;
        calm     = 1'b0;
        seed_words(64'd0);

        directed_rows = '{
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_DRAW,    64'hffff_ffff_ffff_ffff},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_IGNORED, 64'hffff_ffff_ffff_ffff},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_RESEED,  64'h0000_0000_0000_0000},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_RESEED,  64'hffff_ffff_ffff_ffff},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_RESEED,  64'h8000_0000_0000_0000},
            '{OP_RESEED,  64'h0000_0000_0000_0001},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_JUMP,    64'h5555_5555_5555_5555},
            '{OP_DRAW,    64'haaaa_aaaa_aaaa_aaaa},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_IGNORED, 64'h0000_0000_0000_0000},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_RESEED,  64'haaaa_aaaa_aaaa_aaaa},
            '{OP_JUMP,    64'h0000_0000_0000_0000},
            '{OP_JUMP,    64'hffff_ffff_ffff_ffff},
            '{OP_DRAW,    64'h0000_0000_0000_0000},
            '{OP_IGNORED, 64'h0000_0000_0000_0000},
            '{OP_DRAW,    64'h0000_0000_0000_0000}
        };

        // hold reset, release on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(directed_rows[i].op, directed_rows[i].seed);
            source_pause();
        end

        // random part; dropped items do not count toward the total
        taken = 0;
        while (taken < RANDOM_ITEMS) begin
            if (taken >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 84)
                op = OP_DRAW;
            else if (pick < 92)
                op = OP_RESEED;
            else if (pick < 95)
                op = OP_JUMP;
            else
                op = OP_IGNORED;
            if ($urandom_range(0, 4) == 0)
                seed = 64'($urandom_range(0, 15));
            else
                seed = {$urandom, $urandom};
            send_item(op, seed);
            if (op != OP_IGNORED)
                taken++;
            source_pause();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // let pending draws arrive, then watch for stray results
        wait (draw_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
